// ===== hdl/two_mode_frame_deframer_unit_assert.svh =====
// Assertion macros for the deframer checker
`ifndef TWO_MODE_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define TWO_MODE_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent
`define TMFD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define TMFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tmfd_pkg.sv =====
// Shared constants and types for the two-mode frame deframer
package tmfd_pkg;

   localparam int CELL_COUNT  = 9;
   localparam int STORE_DEPTH = 2 * CELL_COUNT;
   localparam int QUEUE_DEPTH = 2;

   localparam int BYTE_W   = 8;
   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 4;
   localparam int CSR_W    = 3;
   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
   localparam int CELL_W   = $clog2(CELL_COUNT + 1);
   localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_CELL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PAIR = 2'd2;

   localparam logic [MODE_W-1:0] RST_FRAME_MODE  = MODE_PAIR;
   localparam logic [BYTE_W-1:0] RST_HEAD_FIRST  = 8'h43;
   localparam logic [BYTE_W-1:0] RST_HEAD_SECOND = 8'h4B;
   localparam logic [BYTE_W-1:0] RST_TAIL_FIRST  = 8'h59;
   localparam logic [BYTE_W-1:0] RST_TAIL_SECOND = 8'h46;

   typedef enum logic [CSR_W-1:0] {
      CSR_FRAME_MODE  = 3'd0,
      CSR_HEAD_FIRST  = 3'd1,
      CSR_HEAD_SECOND = 3'd2,
      CSR_TAIL_FIRST  = 3'd3,
      CSR_TAIL_SECOND = 3'd4
   } csr_index_type;

   typedef enum logic {
      CMD_STORE = 1'b0,
      CMD_EMIT  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic                mode_cell;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hdl/tmfd_req_if.sv =====
// Received-byte channel
interface tmfd_req_if;
   import tmfd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/tmfd_rsp_if.sv =====
// Cell result channel
interface tmfd_rsp_if;
   import tmfd_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] cell_index;
   logic [BYTE_W-1:0]  state_or_x;
   logic [BYTE_W-1:0]  y_coord;
   logic               last_cell;

   modport source (output valid, output cell_index, output state_or_x, output y_coord,
                   output last_cell, input ready);
   modport sink   (input valid, input cell_index, input state_or_x, input y_coord,
                   input last_cell, output ready);
endinterface

// ===== hdl/tmfd_parse.sv =====
// Front end: config registers, frame parser, command generation
module tmfd_parse (
   input  logic                         clock,
   input  logic                         reset,
   tmfd_req_if.sink                     req_ch,
   input  logic                         csr_we,
   input  logic [tmfd_pkg::CSR_W-1:0]   csr_index,
   input  logic [tmfd_pkg::BYTE_W-1:0]  csr_wdata,
   input  tmfd_pkg::queue_status_type   q_status,
   output logic                         push,
   output tmfd_pkg::cmd_type            push_cmd
);
   import tmfd_pkg::*;

   typedef enum logic [2:0] {
      PH_HEAD1   = 3'd0,
      PH_HEAD2   = 3'd1,
      PH_MODE    = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_TAIL1   = 3'd4,
      PH_TAIL2   = 3'd5
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [MODE_W-1:0]  mode_ff;
   logic [BYTE_W-1:0]  head1_ff, head2_ff, tail1_ff, tail2_ff;
   logic               accept;
   logic               mode_ok;
   logic               mode_cell;
   logic [CNT_W-1:0]   len;
   logic [BYTE_W-1:0]  b;

   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.rx_byte;
   assign mode_ok      = (mode_ff == MODE_CELL) || (mode_ff == MODE_PAIR);
   assign mode_cell    = (mode_ff == MODE_CELL);
   assign len          = mode_cell ? CNT_W'(CELL_COUNT) : CNT_W'(STORE_DEPTH);

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      push           = 1'b0;
      push_cmd.kind  = CMD_STORE;
      push_cmd.mode_cell = mode_cell;
      push_cmd.addr  = count_ff[ADDR_W-1:0];
      push_cmd.data  = b;
      if (accept && mode_ok) begin
         case (phase_ff)
            PH_HEAD2: begin
               if (b == head2_ff) phase_in = PH_MODE;
            end
            PH_MODE: begin
               if (b == BYTE_W'(mode_ff)) begin
                  phase_in = PH_PAYLOAD;
                  count_in = '0;
               end
            end
            PH_PAYLOAD: begin
               push     = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (count_in >= len) phase_in = PH_TAIL1;
            end
            PH_TAIL1: begin
               if (b == tail1_ff) phase_in = PH_TAIL2;
            end
            PH_TAIL2: begin
               if (b == tail2_ff) begin
                  phase_in      = PH_HEAD1;
                  count_in      = '0;
                  push          = 1'b1;
                  push_cmd.kind = CMD_EMIT;
               end
            end
            default: begin
               phase_in = (b == head1_ff) ? PH_HEAD2 : PH_HEAD1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD1;
         count_ff <= '0;
         mode_ff  <= RST_FRAME_MODE;
         head1_ff <= RST_HEAD_FIRST;
         head2_ff <= RST_HEAD_SECOND;
         tail1_ff <= RST_TAIL_FIRST;
         tail2_ff <= RST_TAIL_SECOND;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_MODE: begin
                  mode_ff  <= csr_wdata[MODE_W-1:0];
                  phase_ff <= PH_HEAD1;
                  count_ff <= '0;
               end
               CSR_HEAD_FIRST:  head1_ff <= csr_wdata;
               CSR_HEAD_SECOND: head2_ff <= csr_wdata;
               CSR_TAIL_FIRST:  tail1_ff <= csr_wdata;
               CSR_TAIL_SECOND: tail2_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== hdl/tmfd_queue.sv =====
// Short command queue between parser and emitter
module tmfd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  tmfd_pkg::cmd_type           push_cmd,
   input  logic                        pop,
   output tmfd_pkg::cmd_type           head_cmd,
   output tmfd_pkg::queue_status_type  q_status
);
   import tmfd_pkg::*;

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wptr_ff, rptr_ff;
   logic [QCNT_W-1:0]  fill_ff;
   logic               do_push, do_pop;

   assign q_status.full  = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (fill_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_cmd       = entry_ff[rptr_ff];

   function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) wptr_ff <= wrap_inc(wptr_ff);
         if (do_pop)  rptr_ff <= wrap_inc(rptr_ff);
         if (do_push && !do_pop)      fill_ff <= fill_ff + QCNT_W'(1);
         else if (do_pop && !do_push) fill_ff <= fill_ff - QCNT_W'(1);
      end
   end

endmodule

// ===== hdl/tmfd_emit.sv =====
// Back end: payload store and per-cell result sequencer
module tmfd_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  tmfd_pkg::cmd_type           head_cmd,
   input  tmfd_pkg::queue_status_type  q_status,
   output logic                        pop,
   tmfd_rsp_if.source                  rsp_ch
);
   import tmfd_pkg::*;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } emit_state_type;

   emit_state_type      state_ff;
   logic [BYTE_W-1:0]   store_mem [STORE_DEPTH];
   logic [CELL_W-1:0]   cell_ff;
   logic                mode_cell_ff;
   logic                valid_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic [BYTE_W-1:0]   x_ff, y_ff;
   logic                last_ff;
   logic                load;
   logic                final_cell;
   logic [ADDR_W-1:0]   addr_x, addr_y;

   assign pop        = (state_ff == ST_IDLE) && !q_status.empty;
   assign load       = (state_ff == ST_RUN) && (!valid_ff || rsp_ch.ready);
   assign final_cell = (cell_ff == CELL_W'(CELL_COUNT - 1));
   assign addr_x     = mode_cell_ff ? ADDR_W'(cell_ff) : ADDR_W'({cell_ff, 1'b0});
   assign addr_y     = ADDR_W'({cell_ff, 1'b1});

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.cell_index = index_ff;
   assign rsp_ch.state_or_x = x_ff;
   assign rsp_ch.y_coord    = y_ff;
   assign rsp_ch.last_cell  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         cell_ff  <= '0;
      end else begin
         if (load)              valid_ff <= 1'b1;
         else if (rsp_ch.ready) valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  if (head_cmd.kind == CMD_STORE) begin
                     store_mem[head_cmd.addr] <= head_cmd.data;
                  end else begin
                     mode_cell_ff <= head_cmd.mode_cell;
                     cell_ff      <= '0;
                     state_ff     <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               if (load) begin
                  index_ff <= INDEX_W'(cell_ff);
                  x_ff     <= store_mem[addr_x];
                  y_ff     <= mode_cell_ff ? '0 : store_mem[addr_y];
                  last_ff  <= final_cell;
                  cell_ff  <= cell_ff + CELL_W'(1);
                  if (final_cell) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/two_mode_frame_deframer_unit.sv =====
// Top level of the two-mode header/trailer frame deframer
// Takes one received byte per cycle while the two-entry command queue has room; a byte
// that matches nothing in a fixed-byte phase is dropped. Payload bytes go to an
// 18-byte store, one write per cycle while the back end is idle. The closing trailer
// byte releases nine cell results, one per cycle while the result channel is ready,
// out of the store's two read ports; the back end takes the command, then reads out
// the cells, and meanwhile the parser keeps accepting bytes until the queue fills.
// Results leave through a registered output stage.
module two_mode_frame_deframer_unit (
   input  logic                         clock,
   input  logic                         reset,
   tmfd_req_if.sink                     req_ch,
   tmfd_rsp_if.source                   rsp_ch,
   input  logic                         csr_we,
   input  logic [tmfd_pkg::CSR_W-1:0]   csr_index,
   input  logic [tmfd_pkg::BYTE_W-1:0]  csr_wdata
);
   import tmfd_pkg::*;

   logic              push;
   logic              pop;
   cmd_type           push_cmd;
   cmd_type           head_cmd;
   queue_status_type  q_status;

   tmfd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   tmfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   tmfd_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== hdl/tmfd_check.sv =====
// Port-level checker for the deframer, bound to the top level
`include "two_mode_frame_deframer_unit_assert.svh"

module tmfd_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tmfd_pkg::INDEX_W-1:0]  rsp_cell_index,
   input logic                          rsp_last_cell
);
   import tmfd_pkg::*;

   `TMFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `TMFD_ASSERT_SAME(a_last_index, clock, reset, rsp_valid && rsp_last_cell, rsp_cell_index == INDEX_W'(CELL_COUNT - 1), "last flag on wrong cell")
   `TMFD_ASSERT_SAME(a_last_only, clock, reset, rsp_valid && (rsp_cell_index != INDEX_W'(CELL_COUNT - 1)), !rsp_last_cell, "last flag before final cell")
   `TMFD_ASSERT_NEXT(a_burst, clock, reset, rsp_valid && rsp_ready && !rsp_last_cell, rsp_valid, "gap inside frame results")
   `TMFD_ASSERT_SAME(a_reset_idle, clock, reset, $past(reset), !rsp_valid, "result present after reset")

endmodule

bind two_mode_frame_deframer_unit tmfd_check u_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_cell_index (rsp_ch.cell_index),
   .rsp_last_cell  (rsp_ch.last_cell)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the two-mode frame deframer: scripted and random byte streams
`timescale 1ns / 1ps

module tb;
   import tmfd_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 6;
   localparam int IDLE_PERCENT   = 29;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_BYTES    = 47;
   localparam int BURST_PHASE    = 3;
   localparam int CSR_SPARE_LO   = CSR_TAIL_SECOND + 1;
   localparam int CSR_SPARE_HI   = (1 << CSR_W) - 1;

   typedef enum logic [2:0] {
      HUNT_HEAD1, HUNT_HEAD2, HUNT_MODE, IN_PAYLOAD, HUNT_TAIL1, HUNT_TAIL2
   } parse_phase_type;

   typedef struct packed {
      logic [INDEX_W-1:0] cell_index;
      logic [BYTE_W-1:0]  state_or_x;
      logic [BYTE_W-1:0]  y_coord;
      logic               last_cell;
   } cell_result_type;

   typedef enum logic { STEP_RX, STEP_CSR } step_kind_type;

   typedef struct packed {
      step_kind_type     kind;
      logic [CSR_W-1:0]  reg_index;
      logic [BYTE_W-1:0] value;
      logic              typed;
      logic [BYTE_W-1:0] typed_x;
      logic [BYTE_W-1:0] typed_y;
   } script_row_type;

   localparam int SCRIPT_LEN = 25;

   // noise and stray bytes around a mode 1 frame whose payload repeats the header byte,
   // then the unused mode values
   script_row_type script [SCRIPT_LEN] = '{
      '{STEP_CSR, CSR_FRAME_MODE, 8'h01, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h00, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h4B, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h02, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h01, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h46, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h59, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h46, 1'b1, 8'h43, 8'h00},
      '{STEP_CSR, CSR_FRAME_MODE, 8'hFF, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'hFF, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h43, 1'b0, 8'h00, 8'h00},
      '{STEP_CSR, CSR_FRAME_MODE, 8'h00, 1'b0, 8'h00, 8'h00},
      '{STEP_RX,  CSR_FRAME_MODE, 8'h00, 1'b0, 8'h00, 8'h00}
   };

   logic clock = 1'b0;
   logic reset;
   logic             csr_we;
   logic [CSR_W-1:0] csr_index;
   logic [BYTE_W-1:0] csr_wdata;

   tmfd_req_if req_ch ();
   tmfd_rsp_if rsp_ch ();

   two_mode_frame_deframer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // deframer shadow state
   logic [MODE_W-1:0] cfg_mode        = RST_FRAME_MODE;
   logic [BYTE_W-1:0] cfg_head_first  = RST_HEAD_FIRST;
   logic [BYTE_W-1:0] cfg_head_second = RST_HEAD_SECOND;
   logic [BYTE_W-1:0] cfg_tail_first  = RST_TAIL_FIRST;
   logic [BYTE_W-1:0] cfg_tail_second = RST_TAIL_SECOND;
   parse_phase_type   rx_phase        = HUNT_HEAD1;
   int                payload_fill    = 0;
   logic [BYTE_W-1:0] payload_bytes [STORE_DEPTH];

   cell_result_type pending_cells [$];

   bit burst_mode    = 1'b0;
   int fail_count    = 0;
   int bytes_sent    = 0;
   int results_seen  = 0;
   int frames_seen   = 0;
   int settings_used = 0;
   int quiet_cycles  = 0;

   function automatic int frame_len();
      return (cfg_mode == MODE_CELL) ? CELL_COUNT : STORE_DEPTH;
   endfunction

   function automatic void apply_reg_write(input logic [CSR_W-1:0] idx,
                                           input logic [BYTE_W-1:0] v);
      case (idx)
         CSR_FRAME_MODE: begin
            cfg_mode     = v[MODE_W-1:0];
            rx_phase     = HUNT_HEAD1;
            payload_fill = 0;
         end
         CSR_HEAD_FIRST:  cfg_head_first  = v;
         CSR_HEAD_SECOND: cfg_head_second = v;
         CSR_TAIL_FIRST:  cfg_tail_first  = v;
         CSR_TAIL_SECOND: cfg_tail_second = v;
         default: ;
      endcase
   endfunction

   function automatic int deframe_byte(input logic [BYTE_W-1:0] b,
                                       output cell_result_type cells [CELL_COUNT]);
      int n;
      n = 0;
      if (cfg_mode != MODE_CELL && cfg_mode != MODE_PAIR)
         return 0;
      case (rx_phase)
         HUNT_HEAD2: if (b == cfg_head_second) rx_phase = HUNT_MODE;
         HUNT_MODE: if (b == BYTE_W'(cfg_mode)) begin
            rx_phase     = IN_PAYLOAD;
            payload_fill = 0;
         end
         IN_PAYLOAD: begin
            payload_bytes[payload_fill] = b;
            payload_fill++;
            if (payload_fill >= frame_len()) rx_phase = HUNT_TAIL1;
         end
         HUNT_TAIL1: if (b == cfg_tail_first) rx_phase = HUNT_TAIL2;
         HUNT_TAIL2: if (b == cfg_tail_second) begin
            rx_phase     = HUNT_HEAD1;
            payload_fill = 0;
            for (int c = 0; c < CELL_COUNT; c++) begin
               cells[c].cell_index = INDEX_W'(c);
               cells[c].state_or_x = (cfg_mode == MODE_CELL) ? payload_bytes[c]
                                                              : payload_bytes[2*c];
               cells[c].y_coord    = (cfg_mode == MODE_CELL) ? 8'h00 : payload_bytes[2*c+1];
               cells[c].last_cell  = (c == CELL_COUNT - 1);
            end
            n = CELL_COUNT;
         end
         default: rx_phase = (b == cfg_head_first) ? HUNT_HEAD2 : HUNT_HEAD1;
      endcase
      return n;
   endfunction

   function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                       input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] v;
      do v = BYTE_W'($urandom_range(0, 255)); while (v == b);
      return v;
   endfunction

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic typed = 1'b0,
                            input logic [BYTE_W-1:0] typed_x = 8'h00,
                            input logic [BYTE_W-1:0] typed_y = 8'h00);
      cell_result_type cells [CELL_COUNT];
      cell_result_type fixed_cell;
      int n;
      while (!burst_mode && $urandom_range(0, 99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      n = deframe_byte(b, cells);
      bytes_sent++;
      if (typed) begin
         for (int c = 0; c < CELL_COUNT; c++) begin
            fixed_cell = '{INDEX_W'(c), typed_x, typed_y, c == CELL_COUNT - 1};
            pending_cells.push_back(fixed_cell);
         end
      end else begin
         for (int c = 0; c < n; c++) pending_cells.push_back(cells[c]);
      end
   endtask

   // fixed byte, sometimes preceded by a stray byte the parser must skip
   task automatic send_fixed(input logic [BYTE_W-1:0] b);
      if ($urandom_range(0, 7) == 0) push_byte(other_than(b));
      push_byte(b);
   endtask

   task automatic send_frame(input bit bad_mode, input int cut);
      logic [BYTE_W-1:0] fixed [4];
      logic [BYTE_W-1:0] mode_byte;
      int len;
      fixed     = '{cfg_head_first, cfg_head_second, cfg_tail_first, cfg_tail_second};
      mode_byte = BYTE_W'(cfg_mode);
      len       = frame_len();
      send_fixed(cfg_head_first);
      send_fixed(cfg_head_second);
      if (bad_mode) push_byte(other_than(mode_byte));
      else send_fixed(mode_byte);
      for (int i = 0; i < len && i < cut; i++)
         push_byte(($urandom_range(0, 3) == 0) ? fixed[$urandom_range(0, 3)]
                                               : BYTE_W'($urandom_range(0, 255)));
      if (cut < len) return;
      send_fixed(cfg_tail_first);
      send_fixed(cfg_tail_second);
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [BYTE_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      apply_reg_write(idx, v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // drop valid, wait for every result, then let the back end drain
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock)
      rsp_ch.ready <= burst_mode || ($urandom_range(0, 99) >= IDLE_PERCENT);

   always @(posedge clock) begin : result_check
      cell_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_cells.size() == 0) begin
            $error("unexpected cell result: cell_index %0d", rsp_ch.cell_index);
            fail_count++;
         end else begin
            want = pending_cells.pop_front();
            check_field("cell_index", BYTE_W'(want.cell_index), BYTE_W'(rsp_ch.cell_index));
            check_field("state_or_x", want.state_or_x, rsp_ch.state_or_x);
            check_field("y_coord", want.y_coord, rsp_ch.y_coord);
            check_field("last_cell", BYTE_W'(want.last_cell), BYTE_W'(rsp_ch.last_cell));
         end
         results_seen++;
         if (rsp_ch.last_cell) frames_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we)
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : stimulus
      logic [BYTE_W-1:0] rst_bytes [4];
      logic [BYTE_W-1:0] v;
      int start;
      rst_bytes      = '{RST_HEAD_FIRST, RST_HEAD_SECOND, RST_TAIL_FIRST, RST_TAIL_SECOND};
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == STEP_CSR) begin
            settle();
            write_reg(script[i].reg_index, script[i].value);
            settings_used++;
         end else
            push_byte(script[i].value, script[i].typed, script[i].typed_x, script[i].typed_y);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         burst_mode = (p == BURST_PHASE);
         v = BYTE_W'($urandom_range(0, 255));
         v[MODE_W-1:0] = (p % 2 == 0) ? MODE_PAIR : MODE_CELL;
         write_reg(CSR_FRAME_MODE, v);
         for (int k = 0; k < 4; k++) begin
            case (p)
               0:       v = rst_bytes[k];
               1:       v = 8'h00;
               2:       v = 8'hFF;
               default: v = BYTE_W'($urandom_range(0, 255));
            endcase
            write_reg(CSR_W'(CSR_HEAD_FIRST + k), v);
         end
         write_reg(CSR_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                   BYTE_W'($urandom_range(0, 255)));
         settings_used++;
         start = bytes_sent;
         while (bytes_sent < start + PHASE_BYTES) begin
            case ($urandom_range(0, 9))
               7:       repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
               8:       send_frame(1'b0, $urandom_range(0, frame_len() - 1));
               9:       send_frame(1'b1, frame_len());
               default: send_frame(1'b0, frame_len());
            endcase
         end
      end
      burst_mode = 1'b0;
      settle();

      $display("Sent %0d bytes under %0d register settings (both payload modes, unused modes,",
               bytes_sent, settings_used);
      $display("  stray, broken and noise bytes); checked %0d cell results in %0d frames.",
               results_seen, frames_seen);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tmfd_pkg.sv
hdl/tmfd_req_if.sv
hdl/tmfd_rsp_if.sv
hdl/tmfd_parse.sv
hdl/tmfd_queue.sv
hdl/tmfd_emit.sv
hdl/two_mode_frame_deframer_unit.sv
hdl/tmfd_check.sv
tb/sv/tb.sv
